@@ sv/gsb_pkg.sv @@
// gsb_pkg: shared types and constants for the gray sobel edge threshold block
// no dependencies
`timescale 1ns / 1ps

package gsb_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4095;
	localparam int MIN_SIZE   = 3;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int PIX_W      = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_THRESH = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [10:0] width;
		logic [11:0] height;
		logic [7:0]  thresh;
	} cfg_t;

	// one classified pixel handed from the front to the back
	typedef struct packed {
		pix_t [8:0]       win;
		logic [COL_W-1:0] px;
		logic [ROW_W-1:0] py;
		logic             interior;
		logic             border;
		logic             border_edge;
	} job_t;

endpackage

@@ sv/gray_sobel_edge_threshold.sv @@
// gray_sobel_edge_threshold: top level, configuration registers and the front/queue/back chain
// depends on gsb_pkg, gsb_front, gsb_fifo, gsb_back
//
// channel   direction  handshake                  payload
// pixel     in         push / full                blue, green, red
// result    out        empty / pop                pixel_x, pixel_y, edge_res, last_of_run
// config    in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one pixel transaction per cycle while full is low; a pixel that yields both an interior
// and a border result occupies the result port for both, so the sustained rate is set by the result port
// a result passes the intake stage, the queue and the back stages s1, s2, s3 before it can be popped
// reset sets the registers to width 640, height 480, threshold 128 and clears counters
// and window; line stores are not cleared
// full rises only when the four-entry queue and the intake stage are both occupied
`timescale 1ns / 1ps

module gray_sobel_edge_threshold (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	output logic        empty,
	input  logic        pop,
	output logic [9:0]  pixel_x,
	output logic [11:0] pixel_y,
	output logic        edge_res,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import gsb_pkg::*;

	cfg_t cfg_q;
	logic q_push;
	logic q_ready;
	job_t q_wdata;
	logic q_pop;
	logic q_empty;
	job_t q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= 11'd640;
			cfg_q.height <= 12'd480;
			cfg_q.thresh <= 8'd128;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIDTH:  cfg_q.width  <= cfg_data[10:0];
				CFG_HEIGHT: cfg_q.height <= cfg_data;
				CFG_THRESH: cfg_q.thresh <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	gsb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.full    (full),
		.blue    (blue),
		.green   (green),
		.red     (red),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	gsb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_data  (q_wdata),
		.wr_ready (q_ready),
		.rd_en    (q_pop),
		.rd_empty (q_empty),
		.rd_data  (q_rdata)
	);

	gsb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.edge_res    (edge_res),
		.last_of_run (last_of_run)
	);

`ifndef ASSERT_OFF
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_ready)
		else $error("queue written while full");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_of_run) |=> (!empty && last_of_run))
		else $error("second result of a pixel missing");

	a_queue_entry_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_wdata.interior || q_wdata.border))
		else $error("queued pixel without result");
`endif

endmodule

@@ sv/gsb_front.sv @@
// gsb_front: pixel intake, gray conversion, line stores, 3x3 window and classification
// depends on gsb_pkg
`timescale 1ns / 1ps

module gsb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  gsb_pkg::cfg_t cfg,
	input  logic          push,
	output logic          full,
	input  gsb_pkg::pix_t blue,
	input  gsb_pkg::pix_t green,
	input  gsb_pkg::pix_t red,
	input  logic          q_ready,
	output logic          q_push,
	output gsb_pkg::job_t q_data
);
	import gsb_pkg::*;

	localparam logic [9:0]  DIV3_MUL   = 10'd683;
	localparam int          DIV3_SHIFT = 11;

	pix_t             older_mem [MAX_WIDTH];
	pix_t             newer_mem [MAX_WIDTH];
	pix_t [8:0]       win_q;
	pix_t [8:0]       win_next;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic             valid_s1;
	pix_t             gray_s1;
	pix_t             older_s1;
	pix_t             newer_s1;
	logic [COL_W-1:0] x_s1;
	logic [ROW_W-1:0] y_s1;
	logic             int_s1;
	logic             brd_s1;

	logic             accept;
	logic             adv_s1;
	logic [9:0]       sum;
	logic [19:0]      prod;
	pix_t             gray;
	logic [10:0]      w_eff;
	logic [11:0]      h_eff;
	logic [10:0]      x_ext;
	logic [10:0]      x_inc;
	logic [12:0]      y_inc;
	logic             last_col;
	logic             last_row;
	logic             interior;
	logic             border;

	assign adv_s1 = valid_s1 && q_ready;
	assign full   = valid_s1 && !q_ready;
	assign accept = push && !full;

	assign sum  = {2'b00, blue} + {2'b00, green} + {2'b00, red};
	assign prod = 20'(sum) * 20'(DIV3_MUL);
	assign gray = prod[DIV3_SHIFT +: PIX_W];

	always_comb begin
		w_eff = cfg.width;
		if (cfg.width < 11'(MIN_SIZE)) begin
			w_eff = 11'(MIN_SIZE);
		end else if (cfg.width > 11'(MAX_WIDTH)) begin
			w_eff = 11'(MAX_WIDTH);
		end
		h_eff = cfg.height;
		if (cfg.height < 12'(MIN_SIZE)) begin
			h_eff = 12'(MIN_SIZE);
		end else if (cfg.height > 12'(MAX_HEIGHT)) begin
			h_eff = 12'(MAX_HEIGHT);
		end
	end

	assign x_ext    = {1'b0, col_q};
	assign x_inc    = x_ext + 11'd1;
	assign y_inc    = {1'b0, row_q} + 13'd1;
	assign last_col = x_inc >= w_eff;
	assign last_row = y_inc >= {1'b0, h_eff};
	assign interior = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2)) && (x_ext < w_eff)
		&& (row_q < h_eff);
	assign border   = (col_q == '0) || (row_q == '0) || last_col || last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : y_inc[ROW_W-1:0];
				end else begin
					col_q <= x_inc[COL_W-1:0];
				end
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1 <= gray;
			x_s1    <= col_q;
			y_s1    <= row_q;
			int_s1  <= interior;
			brd_s1  <= border;
		end
	end

	// line stores: registered read at intake, write when the pixel leaves s1
	always_ff @(posedge clk) begin
		if (accept) begin
			older_s1 <= older_mem[col_q];
			newer_s1 <= newer_mem[col_q];
		end
		if (adv_s1) begin
			older_mem[x_s1] <= newer_s1;
			newer_mem[x_s1] <= gray_s1;
		end
	end

	always_comb begin
		win_next    = win_q;
		win_next[0] = win_q[1];
		win_next[1] = win_q[2];
		win_next[2] = older_s1;
		win_next[3] = win_q[4];
		win_next[4] = win_q[5];
		win_next[5] = newer_s1;
		win_next[6] = win_q[7];
		win_next[7] = win_q[8];
		win_next[8] = gray_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (adv_s1) begin
			win_q <= win_next;
		end
	end

	// pixels that yield no result are dropped here
	assign q_push = adv_s1 && (int_s1 || brd_s1);

	always_comb begin
		q_data             = '0;
		q_data.win         = win_next;
		q_data.px          = x_s1;
		q_data.py          = y_s1;
		q_data.interior    = int_s1;
		q_data.border      = brd_s1;
		q_data.border_edge = gray_s1 > cfg.thresh;
	end

endmodule

@@ sv/gsb_fifo.sv @@
// gsb_fifo: short queue of classified pixels between front and back
// depends on gsb_pkg
`timescale 1ns / 1ps

module gsb_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  gsb_pkg::job_t wr_data,
	output logic          wr_ready,
	input  logic          rd_en,
	output logic          rd_empty,
	output gsb_pkg::job_t rd_data
);
	import gsb_pkg::*;

	job_t               slots_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign wr_ready = count_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign rd_empty = count_q == '0;
	assign do_wr    = wr_en && wr_ready;
	assign do_rd    = rd_en && !rd_empty;
	assign rd_data  = slots_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + FIFO_AW'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + FIFO_AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (FIFO_AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (FIFO_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wptr_q] <= wr_data;
		end
	end

endmodule

@@ sv/gsb_back.sv @@
// gsb_back: sobel gradients, squared magnitude test and result sequencing
// depends on gsb_pkg
`timescale 1ns / 1ps

module gsb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  gsb_pkg::cfg_t cfg,
	input  logic          q_empty,
	input  gsb_pkg::job_t q_data,
	output logic          q_pop,
	output logic          empty,
	input  logic          pop,
	output logic [9:0]    pixel_x,
	output logic [11:0]   pixel_y,
	output logic          edge_res,
	output logic          last_of_run
);
	import gsb_pkg::*;

	typedef struct packed {
		logic [COL_W-1:0] ix;
		logic [ROW_W-1:0] iy;
		logic [COL_W-1:0] bx;
		logic [ROW_W-1:0] by;
		logic             interior;
		logic             border;
		logic             border_edge;
	} meta_t;

	logic               valid_s1;
	logic signed [11:0] dx_s1;
	logic signed [11:0] dy_s1;
	meta_t              meta_s1;
	logic               valid_s2;
	logic [19:0]        dx2_s2;
	logic [19:0]        dy2_s2;
	meta_t              meta_s2;
	logic               valid_s3;
	logic               int_pend_s3;
	logic               brd_pend_s3;
	logic               int_edge_s3;
	meta_t              meta_s3;

	logic [16:0]        thr_sq_q;
	logic               thr_top_q;
	logic [8:0]         thr_inc;
	logic signed [11:0] dx;
	logic signed [11:0] dy;
	logic [20:0]        mag_sq;
	meta_t              meta_in;
	logic               free_s1;
	logic               free_s2;
	logic               free_s3;
	logic               move_s2;
	logic               move_s1;

	function automatic logic signed [11:0] px_s(input pix_t p);
		return $signed({4'b0000, p});
	endfunction

	assign thr_inc = {1'b0, cfg.thresh} + 9'd1;

	always_ff @(posedge clk) begin
		thr_sq_q  <= 17'(thr_inc) * 17'(thr_inc);
		thr_top_q <= cfg.thresh == 8'hFF;
	end

	assign free_s3 = !valid_s3 || (pop && !(int_pend_s3 && brd_pend_s3));
	assign move_s2 = valid_s2 && free_s3;
	assign free_s2 = !valid_s2 || free_s3;
	assign move_s1 = valid_s1 && free_s2;
	assign free_s1 = !valid_s1 || free_s2;
	assign q_pop   = !q_empty && free_s1;

	always_comb begin
		dx = px_s(q_data.win[2]) - px_s(q_data.win[0])
			+ ((px_s(q_data.win[5]) - px_s(q_data.win[3])) <<< 1)
			+ px_s(q_data.win[8]) - px_s(q_data.win[6]);
		dy = px_s(q_data.win[0]) - px_s(q_data.win[6])
			+ ((px_s(q_data.win[1]) - px_s(q_data.win[7])) <<< 1)
			+ px_s(q_data.win[2]) - px_s(q_data.win[8]);
		meta_in             = '0;
		meta_in.ix          = q_data.px - COL_W'(1);
		meta_in.iy          = q_data.py - ROW_W'(1);
		meta_in.bx          = q_data.px;
		meta_in.by          = q_data.py;
		meta_in.interior    = q_data.interior;
		meta_in.border      = q_data.border;
		meta_in.border_edge = q_data.border_edge;
	end

	assign mag_sq = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			int_pend_s3 <= 1'b0;
			brd_pend_s3 <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				valid_s2 <= 1'b1;
			end else if (move_s2) begin
				valid_s2 <= 1'b0;
			end
			if (move_s2) begin
				valid_s3    <= 1'b1;
				int_pend_s3 <= meta_s2.interior;
				brd_pend_s3 <= meta_s2.border;
			end else if (pop && valid_s3) begin
				priority if (int_pend_s3 && brd_pend_s3) begin
					int_pend_s3 <= 1'b0;
				end else begin
					valid_s3 <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dx_s1   <= dx;
			dy_s1   <= dy;
			meta_s1 <= meta_in;
		end
		if (move_s1) begin
			dx2_s2  <= 20'(21'(dx_s1) * 21'(dx_s1));
			dy2_s2  <= 20'(21'(dy_s1) * 21'(dy_s1));
			meta_s2 <= meta_s1;
		end
		if (move_s2) begin
			int_edge_s3 <= !thr_top_q && (mag_sq >= {4'b0000, thr_sq_q});
			meta_s3     <= meta_s2;
		end
	end

	assign empty       = !valid_s3;
	assign pixel_x     = int_pend_s3 ? meta_s3.ix : meta_s3.bx;
	assign pixel_y     = int_pend_s3 ? meta_s3.iy : meta_s3.by;
	assign edge_res    = int_pend_s3 ? int_edge_s3 : meta_s3.border_edge;
	assign last_of_run = !(int_pend_s3 && brd_pend_s3);

endmodule
